FILE: design/ttt_pkg.sv
`timescale 1ns / 1ps
// Package for the timeout timer table: sizes, request codes, sequencer states
// and the request/response types of the shared adder. No dependencies.
package ttt_pkg;

   localparam int NUM_SLOTS  = 32;
   localparam int SLOT_W     = $clog2(NUM_SLOTS);
   localparam int IDX_W      = $clog2(NUM_SLOTS + 1);
   localparam int RESULT_CAP = 32;
   localparam int CNT_W      = $clog2(RESULT_CAP + 1);
   localparam int TIME_W     = 32;
   localparam int DUR_W      = 24;
   localparam int ACT_W      = 3;
   localparam int ID_W       = 5;
   localparam int REQ_W      = ACT_W + ID_W + DUR_W;
   localparam int RSP_W      = 40;

   localparam logic [ACT_W-1:0] ACT_ADD     = 3'd0;
   localparam logic [ACT_W-1:0] ACT_DELETE  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_UPDATE  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_TICK    = 3'd3;
   localparam logic [ACT_W-1:0] ACT_EXPIRE  = 3'd4;
   localparam logic [ACT_W-1:0] ACT_CLOSEST = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_ARM,
      ST_SCAN,
      ST_FIN
   } state_type;

   typedef enum logic {
      ALU_ADD_SAT,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type        op;
      logic [TIME_W-1:0] a;
      logic [TIME_W-1:0] b;
   } alu_req_type;

   // flag: overflow for ALU_ADD_SAT, borrow (a < b) for ALU_SUB
   typedef struct packed {
      logic [TIME_W-1:0] value;
      logic              flag;
   } alu_rsp_type;

endpackage

FILE: design/ttt_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ttt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/ttt_alu.sv
`timescale 1ns / 1ps
// Shared 32-bit adder: saturating add or subtract with borrow, one carry chain.
// Depends on ttt_pkg.
module ttt_alu (
   input  ttt_pkg::alu_req_type req,
   output ttt_pkg::alu_rsp_type rsp
);

   logic                      is_sub;
   logic [ttt_pkg::TIME_W-1:0] b_eff;
   logic [ttt_pkg::TIME_W:0]   sum;
   logic                      carry;

   always_comb begin
      is_sub = (req.op == ttt_pkg::ALU_SUB);
      b_eff  = is_sub ? ~req.b : req.b;
      sum    = {1'b0, req.a} + {1'b0, b_eff} + {{ttt_pkg::TIME_W{1'b0}}, is_sub};
      carry  = sum[ttt_pkg::TIME_W];
      if (is_sub) begin
         rsp.value = sum[ttt_pkg::TIME_W-1:0];
         rsp.flag  = ~carry;
      end else begin
         rsp.value = carry ? {ttt_pkg::TIME_W{1'b1}} : sum[ttt_pkg::TIME_W-1:0];
         rsp.flag  = carry;
      end
   end

endmodule

FILE: design/timeout_timer_table_unit.sv
`timescale 1ns / 1ps
// Timeout timer table: slot table, time counter and scan sequencer.
// Depends on ttt_pkg, ttt_ram, ttt_alu.
//
// Usage:
//   req channel (req_tvalid/req_tready/req_tdata) carries one request:
//   add, delete, update, tick, expire or closest query.
//   rsp channel (rsp_tvalid/rsp_tready/rsp_tdata/rsp_tlast) carries results;
//   rsp_tlast marks the final result of a request.
//   Delete and unused codes finish in the idle state; tick passes through ST_TICK, add and update through ST_ARM.
//   Expire and closest walk all NUM_SLOTS slots through the deadline RAM's
//   single read port, one slot per cycle while no stalled result holds the
//   scan, with one subtract/compare in the shared adder per slot. Expire gives
//   one result per expired slot in slot order (or one result with
//   expired_valid low); closest gives exactly one result.
//   req_tready is high only while the sequencer is idle.
//   A result sits in an output register; a stalled receiver holds it and
//   stalls the scan at its next expired slot or at the final result.
//   Reset (synchronous, active high) clears the time counter, all active
//   bits and the output valid flag; deadline and duration RAMs are not cleared.
module timeout_timer_table_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [ttt_pkg::REQ_W-1:0]  req_tdata,   // action, slot_id, duration
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [ttt_pkg::RSP_W-1:0]  rsp_tdata,   // expired_slot, expired_valid,
                                                   // time_left, has_timer
   output logic                       rsp_tlast    // last_result
);

   localparam int SW = ttt_pkg::SLOT_W;
   localparam int TW = ttt_pkg::TIME_W;
   localparam int DW = ttt_pkg::DUR_W;

   ttt_pkg::state_type state_ff, state_in;

   logic [ttt_pkg::ACT_W-1:0]  op_action_ff, op_action_in;
   logic [SW-1:0]              op_slot_ff, op_slot_in;
   logic [DW-1:0]              op_dur_ff, op_dur_in;
   logic                       use_stored_ff, use_stored_in;
   logic [TW-1:0]              time_ff, time_in;
   logic [ttt_pkg::NUM_SLOTS-1:0] active_ff, active_in;
   logic [ttt_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic [ttt_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                       pend_valid_ff, pend_valid_in;
   logic [SW-1:0]              pend_slot_ff, pend_slot_in;
   logic                       any_ff, any_in;
   logic [TW-1:0]              best_ff, best_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ttt_pkg::RSP_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic [ttt_pkg::ACT_W-1:0]  req_action;
   logic [ttt_pkg::ID_W-1:0]   req_slot;
   logic [DW-1:0]              req_dur;
   logic                       req_fire;
   logic                       slot_ok;

   logic                       mem_wr_en;
   logic                       mem_rd_en;
   logic [SW-1:0]              mem_rd_addr;
   logic [TW-1:0]              dl_wr_data;
   logic [DW-1:0]              du_wr_data;
   logic [TW-1:0]              dl_rd_data;
   logic [DW-1:0]              du_rd_data;

   ttt_pkg::alu_req_type       alu_req;
   ttt_pkg::alu_rsp_type       alu_rsp;

   logic                       out_free;
   logic                       cur_act;
   logic                       hit;
   logic                       stall;
   logic                       advance;
   logic                       scan_end;
   logic [TW-1:0]              left;

   assign req_action = req_tdata[ttt_pkg::ACT_W-1:0];
   assign req_slot   = req_tdata[ttt_pkg::ACT_W+ttt_pkg::ID_W-1:ttt_pkg::ACT_W];
   assign req_dur    = req_tdata[ttt_pkg::REQ_W-1:ttt_pkg::ACT_W+ttt_pkg::ID_W];
   assign req_tready = (state_ff == ttt_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign slot_ok    = (32'(req_slot) < ttt_pkg::NUM_SLOTS);

   ttt_ram #(.WIDTH(TW), .DEPTH(ttt_pkg::NUM_SLOTS)) u_deadline (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (op_slot_ff),
      .wr_data (dl_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (dl_rd_data)
   );

   ttt_ram #(.WIDTH(DW), .DEPTH(ttt_pkg::NUM_SLOTS)) u_duration (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (op_slot_ff),
      .wr_data (du_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (du_rd_data)
   );

   ttt_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   // shared adder operands and scan decisions
   always_comb begin
      out_free  = !rsp_valid_ff || rsp_tready;
      cur_act   = active_ff[idx_ff[SW-1:0]];
      alu_req   = '{op: ttt_pkg::ALU_SUB, a: time_ff, b: dl_rd_data};
      case (state_ff)
         ttt_pkg::ST_TICK: begin
            alu_req = '{op: ttt_pkg::ALU_ADD_SAT, a: time_ff, b: TW'(1)};
         end
         ttt_pkg::ST_ARM: begin
            alu_req = '{op: ttt_pkg::ALU_ADD_SAT, a: time_ff,
                        b: use_stored_ff ? TW'(du_rd_data) : TW'(op_dur_ff)};
         end
         ttt_pkg::ST_SCAN: begin
            if (op_action_ff == ttt_pkg::ACT_EXPIRE) begin
               alu_req = '{op: ttt_pkg::ALU_SUB, a: time_ff, b: dl_rd_data};
            end else begin
               alu_req = '{op: ttt_pkg::ALU_SUB, a: dl_rd_data, b: best_ff};
            end
         end
         ttt_pkg::ST_FIN: begin
            alu_req = '{op: ttt_pkg::ALU_SUB, a: best_ff, b: time_ff};
         end
         default: begin
            alu_req = '{op: ttt_pkg::ALU_SUB, a: time_ff, b: dl_rd_data};
         end
      endcase
      hit      = (state_ff == ttt_pkg::ST_SCAN) && (op_action_ff == ttt_pkg::ACT_EXPIRE)
                 && cur_act && !alu_rsp.flag;
      stall    = hit && pend_valid_ff && !out_free;
      advance  = (state_ff == ttt_pkg::ST_SCAN) && !stall;
      scan_end = (idx_ff == ttt_pkg::IDX_W'(ttt_pkg::NUM_SLOTS - 1))
                 || (hit && (cnt_ff == ttt_pkg::CNT_W'(ttt_pkg::RESULT_CAP - 1)));
      left     = (any_ff && !alu_rsp.flag) ? alu_rsp.value : '0;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ttt_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_action)
                  ttt_pkg::ACT_ADD,
                  ttt_pkg::ACT_UPDATE:  state_in = slot_ok ? ttt_pkg::ST_ARM : ttt_pkg::ST_IDLE;
                  ttt_pkg::ACT_TICK:    state_in = ttt_pkg::ST_TICK;
                  ttt_pkg::ACT_EXPIRE,
                  ttt_pkg::ACT_CLOSEST: state_in = ttt_pkg::ST_SCAN;
                  default:              state_in = ttt_pkg::ST_IDLE;
               endcase
            end
         end
         ttt_pkg::ST_TICK: state_in = ttt_pkg::ST_IDLE;
         ttt_pkg::ST_ARM:  state_in = ttt_pkg::ST_IDLE;
         ttt_pkg::ST_SCAN: begin
            if (advance && scan_end) begin
               state_in = ttt_pkg::ST_FIN;
            end
         end
         ttt_pkg::ST_FIN: begin
            if (out_free) begin
               state_in = ttt_pkg::ST_IDLE;
            end
         end
         default: state_in = ttt_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      op_action_in  = op_action_ff;
      op_slot_in    = op_slot_ff;
      op_dur_in     = op_dur_ff;
      use_stored_in = use_stored_ff;
      time_in       = time_ff;
      active_in     = active_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      any_in        = any_ff;
      best_in       = best_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = SW'(req_slot);
      dl_wr_data    = alu_rsp.value;
      du_wr_data    = use_stored_ff ? du_rd_data : op_dur_ff;

      case (state_ff)
         ttt_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_action_in  = req_action;
               op_slot_in    = SW'(req_slot);
               op_dur_in     = req_dur;
               use_stored_in = (req_action == ttt_pkg::ACT_UPDATE) && (req_dur == '0);
               case (req_action)
                  ttt_pkg::ACT_DELETE: begin
                     if (slot_ok) begin
                        active_in[SW'(req_slot)] = 1'b0;
                     end
                  end
                  ttt_pkg::ACT_UPDATE: begin
                     mem_rd_en = 1'b1;
                  end
                  ttt_pkg::ACT_EXPIRE,
                  ttt_pkg::ACT_CLOSEST: begin
                     idx_in        = '0;
                     cnt_in        = '0;
                     pend_valid_in = 1'b0;
                     any_in        = 1'b0;
                     best_in       = '1;
                     mem_rd_en     = 1'b1;
                     mem_rd_addr   = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ttt_pkg::ST_TICK: begin
            time_in = alu_rsp.value;
         end
         ttt_pkg::ST_ARM: begin
            mem_wr_en             = 1'b1;
            active_in[op_slot_ff] = 1'b1;
         end
         ttt_pkg::ST_SCAN: begin
            if (advance) begin
               idx_in      = idx_ff + 1'b1;
               mem_rd_en   = !scan_end;
               mem_rd_addr = SW'(idx_ff + 1'b1);
               if (op_action_ff == ttt_pkg::ACT_CLOSEST) begin
                  if (cur_act && (!any_ff || alu_rsp.flag)) begin
                     best_in = dl_rd_data;
                  end
                  any_in = any_ff || cur_act;
               end else if (hit) begin
                  active_in[idx_ff[SW-1:0]] = 1'b0;
                  cnt_in        = cnt_ff + 1'b1;
                  pend_valid_in = 1'b1;
                  pend_slot_in  = idx_ff[SW-1:0];
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = {1'b0, 1'b0, {TW{1'b0}}, 1'b1,
                                     ttt_pkg::ID_W'(pend_slot_ff)};
                     rsp_last_in  = 1'b0;
                  end
               end
            end
         end
         ttt_pkg::ST_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               if (op_action_ff == ttt_pkg::ACT_EXPIRE) begin
                  rsp_data_in = {1'b0, 1'b0, {TW{1'b0}}, pend_valid_ff,
                                 pend_valid_ff ? ttt_pkg::ID_W'(pend_slot_ff)
                                               : {ttt_pkg::ID_W{1'b0}}};
               end else begin
                  rsp_data_in = {1'b0, any_ff, left, 1'b0, {ttt_pkg::ID_W{1'b0}}};
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ttt_pkg::ST_IDLE;
         time_ff       <= '0;
         active_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         any_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         time_ff       <= time_in;
         active_ff     <= active_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         any_ff        <= any_in;
      end
   end

   always_ff @(posedge clock) begin
      op_action_ff  <= op_action_in;
      op_slot_ff    <= op_slot_in;
      op_dur_ff     <= op_dur_in;
      use_stored_ff <= use_stored_in;
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      pend_slot_ff  <= pend_slot_in;
      best_ff       <= best_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: design/ttt_checker.sv
`timescale 1ns / 1ps
// Port-level checks for timeout_timer_table_unit and the bind that attaches them.
// Depends on ttt_pkg.
module ttt_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [ttt_pkg::REQ_W-1:0] req_tdata,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [ttt_pkg::RSP_W-1:0] rsp_tdata,
   input logic                      rsp_tlast
);

   // after reset: idle and no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // scans block new requests
   a_scan_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready
      && (req_tdata[2:0] == ttt_pkg::ACT_EXPIRE || req_tdata[2:0] == ttt_pkg::ACT_CLOSEST)
      |=> !req_tready)
      else $error("request taken during scan");

   // only expiries come before the final result
   a_mid_expired: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[5] && !rsp_tdata[38])
      else $error("non-final result is not an expiry");

   // no request accepted while a multi-result request is still open
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request accepted mid-expire");

endmodule

bind timeout_timer_table_unit ttt_checker u_ttt_checker (.*);
